// ===== rtl/pps_pkg.sv =====
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

  localparam int unsigned TIME_W  = 20;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned CNT_W   = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = 20'hFFFFF;
  localparam logic [SUM_W-1:0]  SUM_MAX  = 24'hFFFFFF;

  // Item mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  slot;
    logic [7:0]  process_id;
    logic [15:0] arrival;
    logic [11:0] burst;
    logic [7:0]  priority_req;
  } pps_in_t;

  typedef struct packed {
    logic [19:0] tick_time;
    logic        idle;
    logic [7:0]  running_id;
    logic        finished;
    logic [19:0] finish_time;
    logic [19:0] turnaround;
    logic [19:0] waiting;
    logic        all_done;
    logic [23:0] total_turnaround;
    logic [23:0] total_waiting;
  } pps_out_t;

  // One process table entry
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [11:0] burst;
    logic [7:0]  prio;
    logic [11:0] remaining;
  } pps_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC,
    ST_EMIT
  } pps_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic tick_start;
    logic rd_issue;
    logic calc;
    logic emit;
  } pps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic n_zero;
    logic scan_last;
  } pps_sts_t;

endpackage

// ===== rtl/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler: controller plus datapath.
//
// Usage: an item on item_i is taken at a clock edge where start is high and
// busy is low. A load item (mode 0) writes one table slot in that cycle and
// gives no result; busy stays low, so loads may follow back to back.
// A tick item (mode 1) scans the table one slot per cycle through the table
// memory's single read port, then passes through a drain state, a calc state
// that applies the winner and an emit state that builds the result; scan and
// drain are skipped when no slot is in use. busy stays high until the emit
// state is left, and result_o appears with result_valid_o for exactly one
// cycle, registered from the emit state. The next item may be taken in that
// same result cycle.
// The receiver cannot stall: a result is valid only in its single cycle.
// process_count is written on the cfg channel (cfg_valid_i and cfg_ready_o);
// cfg_ready_o is high whenever busy is low.
// Reset clears time, totals and done flags and sets process_count to 1.
// Table slot contents are undefined until loaded.
module preemptive_priority_scheduler #(
  parameter int unsigned PROCS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  pps_pkg::pps_in_t          item_i,
  output logic                      result_valid_o,
  output pps_pkg::pps_out_t         result_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pps_pkg::CNT_W-1:0] cfg_data_i
);
  import pps_pkg::*;

  pps_cmd_t cmd;
  pps_sts_t sts;

  assign cfg_ready_o = ~busy;

  pps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (item_i.mode),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  pps_dp #(
    .PROCS (PROCS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // A result beat only shows while the block is free again
  a_result_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // Each tick gives a single one-cycle beat
  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // An accepted tick occupies the block
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode == MODE_TICK) |=> busy)
    else $error("tick accepted without going busy");

  // A load completes in its accept cycle
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode == MODE_LOAD) |=> (!busy && !result_valid_o))
    else $error("load made the block busy or gave a result");

endmodule

// ===== rtl/pps_ctrl.sv =====
// Sequencing state machine for load and tick items.
module pps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              mode_i,
  input  pps_pkg::pps_sts_t sts_i,
  output pps_pkg::pps_cmd_t cmd_o,
  output logic              busy
);
  import pps_pkg::*;

  pps_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && mode_i == MODE_TICK) begin
          state_d = sts_i.n_zero ? ST_CALC : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_CALC;
      ST_CALC:  state_d = ST_EMIT;
      ST_EMIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy             = 1'b0;
        cmd_o.load       = start && (mode_i == MODE_LOAD);
        cmd_o.tick_start = start && (mode_i == MODE_TICK);
      end
      ST_SCAN:  cmd_o.rd_issue = 1'b1;
      ST_DRAIN: cmd_o = '0;
      ST_CALC:  cmd_o.calc = 1'b1;
      ST_EMIT:  cmd_o.emit = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/pps_dp.sv =====
// Process table, scan compare, completion arithmetic and result register.
module pps_dp #(
  parameter int unsigned PROCS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pps_pkg::pps_cmd_t        cmd_i,
  input  pps_pkg::pps_in_t         item_i,
  input  logic                     cfg_we_i,
  input  logic [pps_pkg::CNT_W-1:0] cfg_data_i,
  output pps_pkg::pps_sts_t        sts_o,
  output logic                     result_valid_o,
  output pps_pkg::pps_out_t        result_o
);
  import pps_pkg::*;

  localparam int unsigned IW = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int unsigned CW = $clog2(PROCS + 1);
  localparam int unsigned NW = (CW > CNT_W) ? CW : CNT_W;

  // Process count register and clamped slots in use
  logic [CNT_W-1:0] count_q;
  logic [NW-1:0]    n_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign n_w = (NW'(count_q) > NW'(PROCS)) ? NW'(PROCS) : NW'(count_q);

  // Table memory and done flags
  pps_entry_t       mem_q [PROCS];
  pps_entry_t       rd_q;
  pps_entry_t       wr_data;
  logic [IW-1:0]    wr_addr;
  logic             wr_en;
  logic [PROCS-1:0] done_q;
  logic             load_ok;

  logic [IW-1:0]    idx_q;
  logic [IW-1:0]    rd_idx_q;
  logic             rd_pend_q;

  pps_entry_t       best_q;
  logic [IW-1:0]    best_idx_q;
  logic             found_q;

  logic             fin_w;
  logic [11:0]      rem_dec;

  assign load_ok = cmd_i.load && ({4'b0, item_i.slot} < 8'(PROCS));
  assign fin_w   = found_q && (best_q.remaining <= 12'd1);
  assign rem_dec = fin_w ? 12'd0 : best_q.remaining - 12'd1;

  // Select the write port between a load and the tick writeback
  always_comb begin
    if (cmd_i.load) begin
      wr_en           = load_ok;
      wr_addr         = IW'(item_i.slot);
      wr_data.id      = item_i.process_id;
      wr_data.arrival = item_i.arrival;
      wr_data.burst   = item_i.burst;
      wr_data.prio    = item_i.priority_req;
      wr_data.remaining = item_i.burst;
    end else begin
      wr_en             = cmd_i.calc && found_q;
      wr_addr           = best_idx_q;
      wr_data           = best_q;
      wr_data.remaining = rem_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else if (load_ok) begin
      done_q[IW'(item_i.slot)] <= 1'b0;
    end else if (cmd_i.calc && fin_w) begin
      done_q[best_idx_q] <= 1'b1;
    end
  end

  // Scan index and read pipeline
  assign sts_o.n_zero    = (n_w == '0);
  assign sts_o.scan_last = (NW'(idx_q) == n_w - NW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      rd_pend_q <= cmd_i.rd_issue;
      if (cmd_i.tick_start) begin
        idx_q <= '0;
      end else if (cmd_i.rd_issue) begin
        idx_q    <= idx_q + IW'(1);
        rd_idx_q <= idx_q;
      end
    end
  end

  // Compare the slot read last cycle against the best so far
  logic [TIME_W-1:0] time_q;
  logic              elig;
  logic              better;

  assign elig   = rd_pend_q && !done_q[rd_idx_q] && (TIME_W'(rd_q.arrival) <= time_q);
  assign better = !found_q || (rd_q.prio > best_q.prio)
               || ((rd_q.prio == best_q.prio) && (rd_q.arrival < best_q.arrival));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.tick_start) begin
      found_q <= 1'b0;
    end else if (elig && better) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (elig && better) begin
      best_q     <= rd_q;
      best_idx_q <= rd_idx_q;
    end
  end

  // Completion: finish time, turnaround, time advance
  logic [TIME_W-1:0] next_time;
  logic [TIME_W-1:0] tat_w;
  logic [TIME_W-1:0] tick_time_q;
  logic [TIME_W-1:0] fin_time_q;
  logic [TIME_W-1:0] tat_q;
  logic              fin_q;
  logic              idle_q;

  assign next_time = (time_q == TIME_MAX) ? TIME_MAX : time_q + TIME_W'(1);
  assign tat_w     = next_time - TIME_W'(best_q.arrival);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      fin_q  <= 1'b0;
      idle_q <= 1'b1;
    end else if (cmd_i.calc) begin
      time_q <= next_time;
      fin_q  <= fin_w;
      idle_q <= !found_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      tick_time_q <= time_q;
      fin_time_q  <= next_time;
      tat_q       <= tat_w;
    end
  end

  // Waiting time, saturating totals and all-done check
  logic [SUM_W-1:0]  sum_tat_q;
  logic [SUM_W-1:0]  sum_wt_q;
  logic [TIME_W-1:0] wt_w;
  logic [SUM_W:0]    tat_acc;
  logic [SUM_W:0]    wt_acc;
  logic [SUM_W-1:0]  sum_tat_d;
  logic [SUM_W-1:0]  sum_wt_d;
  logic [PROCS-1:0]  in_use;
  logic              all_done_w;

  assign wt_w = (tat_q >= TIME_W'(best_q.burst)) ? tat_q - TIME_W'(best_q.burst) : '0;
  assign tat_acc   = {1'b0, sum_tat_q} + (SUM_W + 1)'(tat_q);
  assign wt_acc    = {1'b0, sum_wt_q} + (SUM_W + 1)'(wt_w);
  assign sum_tat_d = tat_acc[SUM_W] ? SUM_MAX : tat_acc[SUM_W-1:0];
  assign sum_wt_d  = wt_acc[SUM_W] ? SUM_MAX : wt_acc[SUM_W-1:0];

  always_comb begin
    for (int i = 0; i < PROCS; i++) begin
      in_use[i] = (NW'(i) < n_w);
    end
  end

  assign all_done_w = &(done_q | ~in_use);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_tat_q <= '0;
      sum_wt_q  <= '0;
    end else if (cmd_i.emit && fin_q) begin
      sum_tat_q <= sum_tat_d;
      sum_wt_q  <= sum_wt_d;
    end
  end

  // Result register, shown for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_o.tick_time        <= tick_time_q;
      result_o.idle             <= idle_q;
      result_o.running_id       <= idle_q ? 8'd0 : best_q.id;
      result_o.finished         <= fin_q;
      result_o.finish_time      <= fin_q ? fin_time_q : '0;
      result_o.turnaround       <= fin_q ? tat_q : '0;
      result_o.waiting          <= fin_q ? wt_w : '0;
      result_o.all_done         <= all_done_w;
      result_o.total_turnaround <= fin_q ? sum_tat_d : sum_tat_q;
      result_o.total_waiting    <= fin_q ? sum_wt_d : sum_wt_q;
    end
  end

endmodule
